// ===== design/sds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared constants, register map and controller state type.
// ----------------------------------------------------------------------------
package sds_pkg;

   // default sizing
   localparam int MAX_BATCH_DEF  = 32;
   localparam int TRACK_BITS_DEF = 16;

   // average seek fraction bits (unsigned Q.8)
   localparam int AVG_FRAC = 8;

   // register widths and reset values
   localparam int MAX_RANGE_W  = 17;
   localparam int HEAD_START_W = 16;
   localparam logic [MAX_RANGE_W-1:0]  MAX_RANGE_RST  = 17'd200;
   localparam logic [HEAD_START_W-1:0] HEAD_START_RST = 16'd0;

   // register bus
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_SEL_BIT = 2;

   // register index (word address bit)
   localparam logic REG_MAX_RANGE  = 1'b0;
   localparam logic REG_HEAD_START = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_PREP,
      ST_UP,
      ST_TGT,
      ST_LO,
      ST_DIV
   } sds_state_type;

endpackage

// ===== design/sds_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler track store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sds_store #(
   parameter int DEPTH  = sds_pkg::MAX_BATCH_DEF,
   parameter int WIDTH  = sds_pkg::TRACK_BITS_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sds_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler average divider
// Restoring divider, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module sds_div #(
   parameter int DVD_W = 30,
   parameter int DVS_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      ge      = (trial >= {1'b0, dvs_ff});
      diff    = trial - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (run_ff) begin
         rem_in  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/scan_disk_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler core
// Collects a batch of track requests and plays out the elevator sweep.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Requests at or above
// head_start are kept sorted ascending in the upper store, the rest sorted
// ascending in the lower store; each request is placed by insertion, moving
// one stored entry per cycle through the store's write and read ports. The
// request marked last then starts the sweep: one move per cycle up the upper
// store, one move to track max_range-1 (skipped if the head is there), one
// move per cycle down the lower store, then a serial divide for the Q.8
// average before the final move leaves. Each move appears on the rsp_ ports
// for exactly one cycle with rsp_strobe high; there is no back-pressure, so
// the receiver must take every transaction as it comes. Once MAX_BATCH
// requests are held further requests are dropped, but a dropped request
// marked last still closes the batch. Configuration writes go through the
// APB-style port; the user must make them only while the block is idle,
// as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_core #(
   parameter int MAX_BATCH  = sds_pkg::MAX_BATCH_DEF,
   parameter int TRACK_BITS = sds_pkg::TRACK_BITS_DEF,
   localparam int TOTAL_W   = TRACK_BITS + $clog2(MAX_BATCH + 2),
   localparam int AVG_W     = TOTAL_W + sds_pkg::AVG_FRAC
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic [TRACK_BITS-1:0]           req_track,
   input  logic                            req_last,
   // move channel
   output logic                            rsp_strobe,
   output logic [TRACK_BITS-1:0]           rsp_from_track,
   output logic [TRACK_BITS-1:0]           rsp_to_track,
   output logic [TRACK_BITS-1:0]           rsp_distance,
   output logic [TOTAL_W-1:0]              rsp_total_seek,
   output logic [AVG_W-1:0]                rsp_average_seek,
   output logic                            rsp_final_move,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sds_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [sds_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [sds_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int CNT_W = $clog2(MAX_BATCH + 1);
   localparam int IDX_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   // compare and target widths cover both the register and the track width
   localparam int HS_W  = (sds_pkg::HEAD_START_W > TRACK_BITS) ?
                          sds_pkg::HEAD_START_W : TRACK_BITS;
   localparam int MR_W  = (sds_pkg::MAX_RANGE_W > TRACK_BITS) ?
                          sds_pkg::MAX_RANGE_W : TRACK_BITS;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [sds_pkg::MAX_RANGE_W-1:0]  max_range_ff;
   logic [sds_pkg::HEAD_START_W-1:0] head_start_ff;
   logic                             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff  <= sds_pkg::MAX_RANGE_RST;
         head_start_ff <= sds_pkg::HEAD_START_RST;
      end else if (csr_wr) begin
         case (paddr[sds_pkg::CSR_SEL_BIT])
            sds_pkg::REG_MAX_RANGE:  max_range_ff  <= pwdata[sds_pkg::MAX_RANGE_W-1:0];
            sds_pkg::REG_HEAD_START: head_start_ff <= pwdata[sds_pkg::HEAD_START_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[sds_pkg::CSR_SEL_BIT])
         sds_pkg::REG_MAX_RANGE:  prdata = sds_pkg::CSR_DATA_W'(max_range_ff);
         sds_pkg::REG_HEAD_START: prdata = sds_pkg::CSR_DATA_W'(head_start_ff);
         default:                 prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Derived configuration values
   // ------------------------------------------------------------------
   logic [HS_W-1:0]       head_ext;
   logic [MR_W-1:0]       target_full;
   logic [TRACK_BITS-1:0] target;
   logic [TRACK_BITS-1:0] head_track;

   assign head_ext    = HS_W'(head_start_ff);
   assign head_track  = head_ext[TRACK_BITS-1:0];
   // max_range of zero wraps to the all-ones track
   assign target_full = MR_W'(max_range_ff) - MR_W'(1);
   assign target      = target_full[TRACK_BITS-1:0];

   // ------------------------------------------------------------------
   // Track stores
   // ------------------------------------------------------------------
   logic                  up_we, lo_we;
   logic [IDX_W-1:0]      up_waddr, lo_waddr, up_raddr, lo_raddr;
   logic [TRACK_BITS-1:0] up_wdata, lo_wdata, up_rdata, lo_rdata;

   sds_store #(
      .DEPTH  (MAX_BATCH),
      .WIDTH  (TRACK_BITS),
      .ADDR_W (IDX_W)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (up_waddr),
      .wr_data (up_wdata),
      .rd_addr (up_raddr),
      .rd_data (up_rdata)
   );

   sds_store #(
      .DEPTH  (MAX_BATCH),
      .WIDTH  (TRACK_BITS),
      .ADDR_W (IDX_W)
   ) u_lower_store (
      .clock   (clock),
      .wr_en   (lo_we),
      .wr_addr (lo_waddr),
      .wr_data (lo_wdata),
      .rd_addr (lo_raddr),
      .rd_data (lo_rdata)
   );

   // ------------------------------------------------------------------
   // Average divider
   // ------------------------------------------------------------------
   logic               div_start;
   logic               div_done;
   logic [AVG_W-1:0]   div_quo;
   logic [CNT_W:0]     cnt_sum;
   logic [TOTAL_W-1:0] total_ff, total_in;

   sds_div #(
      .DVD_W (AVG_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({total_ff, {sds_pkg::AVG_FRAC{1'b0}}}),
      .divisor  (cnt_sum[CNT_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------------
   // Controller state
   // ------------------------------------------------------------------
   sds_pkg::sds_state_type state_ff, state_in;

   logic [CNT_W-1:0]      up_cnt_ff, up_cnt_in;
   logic [CNT_W-1:0]      lo_cnt_ff, lo_cnt_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic                  sel_up_ff, sel_up_in;
   logic                  last_ff, last_in;
   logic [TRACK_BITS-1:0] item_ff, item_in;
   logic [TRACK_BITS-1:0] cur_ff, cur_in;

   // move held back until the next one shows whether it is the final one
   logic                  pend_vld_ff, pend_vld_in;
   logic [TRACK_BITS-1:0] pend_from_ff, pend_from_in;
   logic [TRACK_BITS-1:0] pend_to_ff, pend_to_in;
   logic [TRACK_BITS-1:0] pend_dist_ff, pend_dist_in;
   logic [TOTAL_W-1:0]    pend_total_ff, pend_total_in;

   // result registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [TRACK_BITS-1:0] rsp_from_ff, rsp_from_in;
   logic [TRACK_BITS-1:0] rsp_to_ff, rsp_to_in;
   logic [TRACK_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic [AVG_W-1:0]      rsp_avg_ff, rsp_avg_in;
   logic                  rsp_final_ff, rsp_final_in;

   logic                  accept;
   logic                  fits;
   logic                  go_up;
   logic [CNT_W-1:0]      pos_m1, pos_m2, pos_p1;
   logic [CNT_W-1:0]      lo_cnt_m1;
   logic [TRACK_BITS-1:0] ins_rd;
   logic                  mv_en;
   logic [TRACK_BITS-1:0] mv_to;
   logic [TRACK_BITS-1:0] mv_dist;
   logic [TOTAL_W-1:0]    mv_total;

   assign busy      = (state_ff != sds_pkg::ST_IDLE);
   assign accept    = start & ~busy;
   assign cnt_sum   = {1'b0, up_cnt_ff} + {1'b0, lo_cnt_ff};
   assign fits      = (cnt_sum < (CNT_W + 1)'(MAX_BATCH));
   assign go_up     = (HS_W'(req_track) >= head_ext);
   assign pos_m1    = pos_ff - CNT_W'(1);
   assign pos_m2    = pos_ff - CNT_W'(2);
   assign pos_p1    = pos_ff + CNT_W'(1);
   assign lo_cnt_m1 = lo_cnt_ff - CNT_W'(1);
   assign ins_rd    = sel_up_ff ? up_rdata : lo_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      up_cnt_in     = up_cnt_ff;
      lo_cnt_in     = lo_cnt_ff;
      pos_in        = pos_ff;
      sel_up_in     = sel_up_ff;
      last_in       = last_ff;
      item_in       = item_ff;
      cur_in        = cur_ff;
      total_in      = total_ff;
      pend_vld_in   = pend_vld_ff;
      pend_from_in  = pend_from_ff;
      pend_to_in    = pend_to_ff;
      pend_dist_in  = pend_dist_ff;
      pend_total_in = pend_total_ff;
      rsp_strobe_in = 1'b0;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_final_in  = rsp_final_ff;
      up_we         = 1'b0;
      lo_we         = 1'b0;
      up_waddr      = pos_ff[IDX_W-1:0];
      lo_waddr      = pos_ff[IDX_W-1:0];
      up_wdata      = item_ff;
      lo_wdata      = item_ff;
      up_raddr      = '0;
      lo_raddr      = '0;
      div_start     = 1'b0;
      mv_en         = 1'b0;
      mv_to         = target;

      case (state_ff)
         sds_pkg::ST_IDLE: begin
            // read the top entry of the chosen store for the insertion walk
            up_raddr = up_cnt_ff[IDX_W-1:0] - IDX_W'(1);
            lo_raddr = lo_cnt_ff[IDX_W-1:0] - IDX_W'(1);
            if (accept) begin
               last_in = req_last;
               if (fits) begin
                  sel_up_in = go_up;
                  item_in   = req_track;
                  state_in  = sds_pkg::ST_INS;
                  if (go_up) begin
                     pos_in    = up_cnt_ff;
                     up_cnt_in = up_cnt_ff + CNT_W'(1);
                  end else begin
                     pos_in    = lo_cnt_ff;
                     lo_cnt_in = lo_cnt_ff + CNT_W'(1);
                  end
               end else if (req_last) begin
                  // batch full: request dropped, batch still closes
                  state_in = sds_pkg::ST_PREP;
               end
            end
         end

         sds_pkg::ST_INS: begin
            // hole at pos; read data is entry pos-1
            up_raddr = pos_m2[IDX_W-1:0];
            lo_raddr = pos_m2[IDX_W-1:0];
            up_we    = sel_up_ff;
            lo_we    = ~sel_up_ff;
            if ((pos_ff == '0) || (ins_rd <= item_ff)) begin
               state_in = last_ff ? sds_pkg::ST_PREP : sds_pkg::ST_IDLE;
            end else begin
               up_wdata = ins_rd;
               lo_wdata = ins_rd;
               pos_in   = pos_m1;
            end
         end

         sds_pkg::ST_PREP: begin
            up_raddr    = '0;
            pos_in      = '0;
            cur_in      = head_track;
            total_in    = '0;
            pend_vld_in = 1'b0;
            state_in    = sds_pkg::ST_UP;
         end

         sds_pkg::ST_UP: begin
            up_raddr = pos_p1[IDX_W-1:0];
            if (pos_ff < up_cnt_ff) begin
               mv_en  = 1'b1;
               mv_to  = up_rdata;
               pos_in = pos_p1;
            end else begin
               state_in = sds_pkg::ST_TGT;
            end
         end

         sds_pkg::ST_TGT: begin
            lo_raddr = lo_cnt_m1[IDX_W-1:0];
            pos_in   = lo_cnt_ff;
            mv_en    = (cur_ff != target);
            mv_to    = target;
            state_in = sds_pkg::ST_LO;
         end

         sds_pkg::ST_LO: begin
            lo_raddr = pos_m2[IDX_W-1:0];
            if (pos_ff != '0) begin
               mv_en  = 1'b1;
               mv_to  = lo_rdata;
               pos_in = pos_m1;
            end else begin
               div_start = 1'b1;
               state_in  = sds_pkg::ST_DIV;
            end
         end

         sds_pkg::ST_DIV: begin
            if (div_done) begin
               rsp_strobe_in = 1'b1;
               rsp_from_in   = pend_from_ff;
               rsp_to_in     = pend_to_ff;
               rsp_dist_in   = pend_dist_ff;
               rsp_total_in  = pend_total_ff;
               rsp_avg_in    = div_quo;
               rsp_final_in  = 1'b1;
               pend_vld_in   = 1'b0;
               up_cnt_in     = '0;
               lo_cnt_in     = '0;
               state_in      = sds_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sds_pkg::ST_IDLE;
         end
      endcase

      // one head move: absolute distance and running total
      mv_dist  = (mv_to >= cur_ff) ? (mv_to - cur_ff) : (cur_ff - mv_to);
      mv_total = total_ff + TOTAL_W'(mv_dist);
      if (mv_en) begin
         if (pend_vld_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_from_in   = pend_from_ff;
            rsp_to_in     = pend_to_ff;
            rsp_dist_in   = pend_dist_ff;
            rsp_total_in  = pend_total_ff;
            rsp_avg_in    = '0;
            rsp_final_in  = 1'b0;
         end
         pend_vld_in   = 1'b1;
         pend_from_in  = cur_ff;
         pend_to_in    = mv_to;
         pend_dist_in  = mv_dist;
         pend_total_in = mv_total;
         cur_in        = mv_to;
         total_in      = mv_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_cnt_ff     <= '0;
         lo_cnt_ff     <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         up_cnt_ff     <= up_cnt_in;
         lo_cnt_ff     <= lo_cnt_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      sel_up_ff     <= sel_up_in;
      last_ff       <= last_in;
      item_ff       <= item_in;
      cur_ff        <= cur_in;
      total_ff      <= total_in;
      pend_from_ff  <= pend_from_in;
      pend_to_ff    <= pend_to_in;
      pend_dist_ff  <= pend_dist_in;
      pend_total_ff <= pend_total_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_final_ff  <= rsp_final_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_from_track   = rsp_from_ff;
   assign rsp_to_track     = rsp_to_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_total_seek   = rsp_total_ff;
   assign rsp_average_seek = rsp_avg_ff;
   assign rsp_final_move   = rsp_final_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // both stores together never hold more than a batch
   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_sum <= (CNT_W + 1)'(MAX_BATCH))
      else $error("store counts exceed batch size");

   // insertion hole always lies inside the filled part of its store
   a_ins_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sds_pkg::ST_INS) |->
         (pos_ff < (sel_up_ff ? up_cnt_ff : lo_cnt_ff)))
      else $error("insertion position outside store");

   // final move leaves the block idle with empty stores
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_move) |->
         (!busy && (up_cnt_ff == '0) && (lo_cnt_ff == '0)))
      else $error("batch not cleared after final move");

   // earlier moves only come out while the sweep is still running
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_final_move) |-> busy)
      else $error("non-final move while idle");

endmodule
